// File: rtl/core/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants for the Poisson stencil sweep core.
// ----------------------------------------------------------------------------
package pss_pkg;

  // line-buffer and sine store depth; row and column fields are 10 bits
  localparam int unsigned MAX_GRID  = 1024;
  localparam int unsigned SINE_FRAC = 23;

  typedef enum logic [2:0] {
    CFG_GRID      = 3'd0,
    CFG_METHOD    = 3'd1,
    CFG_FORCE_EN  = 3'd2,
    CFG_SCALE     = 3'd3,
    CFG_RESID_EN  = 3'd4,
    CFG_PRECISION = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_GRID = 1'b0,
    OP_LOAD = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FORCE1,
    ST_FORCE2,
    ST_CALC,
    ST_EMIT1,
    ST_EMIT2
  } state_t;

  // result beat
  typedef struct packed {
    logic [31:0] value;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        last;
    logic [30:0] peak;
    logic        conv;
  } result_t;

endpackage

// File: rtl/core/poisson_stencil_sweep_core.sv
// ----------------------------------------------------------------------------
// poisson_stencil_sweep_core
// One sweep of a five-point Poisson stencil over a raster-ordered grid.
// ----------------------------------------------------------------------------
// A grid beat passes through these states in order: the idle state that accepts
// it, a read of the line-buffer and sine memories (registered), the two forcing
// multiplications (a 31x24 then a 32x24 product, each registered), the stencil
// sum, saturation and residual update, and an output state for each possible
// result. Each output state that has a result also waits while a held result
// is stalled. A sine load is written in the read state, which then returns to
// idle. One beat is in flight at a time; the output register holds a result
// until taken.
module poisson_stencil_sweep_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic signed [31:0] in_grid_value,
  input  logic [9:0]  in_table_index,
  input  logic [23:0] in_table_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_point_value,
  output logic [9:0]  out_point_row,
  output logic [9:0]  out_point_col,
  output logic        out_sweep_last,
  output logic [30:0] out_max_residual,
  output logic        out_converged
);

  localparam int unsigned AW = (pss_pkg::MAX_GRID > 1) ? $clog2(pss_pkg::MAX_GRID) : 1;
  localparam logic [10:0] NMAX = 11'(pss_pkg::MAX_GRID - 1);

  // configuration
  logic [9:0]  grid_r;
  logic        method_r, force_en_r, resid_en_r;
  logic [30:0] scale_r, prec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r     <= 10'd8;
      method_r   <= 1'b0;
      force_en_r <= 1'b0;
      scale_r    <= '0;
      resid_en_r <= 1'b1;
      prec_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pss_pkg::CFG_GRID:      grid_r     <= cfg_wdata[9:0];
        pss_pkg::CFG_METHOD:    method_r   <= cfg_wdata[0];
        pss_pkg::CFG_FORCE_EN:  force_en_r <= cfg_wdata[0];
        pss_pkg::CFG_SCALE:     scale_r    <= cfg_wdata;
        pss_pkg::CFG_RESID_EN:  resid_en_r <= cfg_wdata[0];
        pss_pkg::CFG_PRECISION: prec_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective N, clamped
  logic [10:0] n_eff;
  always_comb begin
    n_eff = {1'b0, grid_r};
    if (n_eff < 11'd2) n_eff = 11'd2;
    if (n_eff > NMAX) n_eff = NMAX;
  end

  // memories
  logic [31:0] centre_mem [pss_pkg::MAX_GRID];
  logic [31:0] upper_mem  [pss_pkg::MAX_GRID];
  logic [23:0] sine_mem   [pss_pkg::MAX_GRID];

  pss_pkg::state_t state_r, state_nxt;

  // captured beat
  logic [31:0] x_r;
  logic [9:0]  r_r, c_r;
  logic        op_r;
  logic [9:0]  tidx_r;
  logic [23:0] tval_r;

  // counters and running state
  logic [9:0]  row_r, col_r;
  logic [31:0] left_r;
  logic [30:0] peak_r;

  // read data
  logic [31:0] old_rd, up_rd, right_rd;
  logic [23:0] sr_rd, sc_rd;

  // forcing pipeline
  logic [31:0] t_r;
  logic [32:0] f_r;

  // result holding
  pss_pkg::result_t res1_r, res2_r;
  logic has1_r, has2_r;
  pss_pkg::result_t out_r;
  logic out_v_r;

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != pss_pkg::ST_IDLE);

  // position actually used by this beat (wrap if grid shrank)
  logic [9:0] r_use, c_use;
  always_comb begin
    r_use = row_r;
    c_use = col_r;
    if ({1'b0, row_r} > n_eff || {1'b0, col_r} > n_eff) begin
      r_use = '0;
      c_use = '0;
    end
  end

  logic [9:0] cp1;
  assign cp1 = c_r + 10'd1;

  // memory reads in ST_READ; address from the captured beat
  always_ff @(posedge clk) begin
    if (state_r == pss_pkg::ST_READ) begin
      old_rd   <= centre_mem[c_r[AW-1:0]];
      up_rd    <= upper_mem[c_r[AW-1:0]];
      right_rd <= centre_mem[cp1[AW-1:0]];
      sr_rd    <= sine_mem[(r_r - 10'd1)];
      sc_rd    <= sine_mem[c_r[AW-1:0]];
    end
  end

  // stencil arithmetic
  logic interior;
  logic signed [33:0] sum;
  logic signed [33:0] q;
  logic signed [35:0] nv_full;
  logic signed [31:0] nv;
  logic signed [33:0] diff;
  logic [33:0] mag;
  logic [30:0] d31;
  logic [30:0] peak_new;
  logic [54:0] prod1;
  logic [55:0] prod2;

  assign prod1 = 55'(scale_r) * 55'(sr_rd) + 55'(1 << (pss_pkg::SINE_FRAC - 1));
  assign prod2 = 56'(t_r) * 56'(sc_rd) + 56'(1 << (pss_pkg::SINE_FRAC - 1));

  always_comb begin
    interior = (r_r >= 10'd2) && ({1'b0, r_r} <= n_eff) && (c_r >= 10'd1)
               && ({1'b0, c_r} + 11'd1 <= n_eff);
    sum = 34'(signed'(up_rd)) + 34'(signed'(left_r)) + 34'(signed'(right_rd))
          + 34'(signed'(x_r));
    q = sum >>> 2;
    nv_full = 36'(q) + (force_en_r ? signed'({3'b000, f_r}) : 36'sd0);
    if (!interior) nv = old_rd;
    else if (nv_full > 36'sh07FFFFFFF) nv = 32'h7FFFFFFF;
    else if (nv_full < -36'sh080000000) nv = 32'h80000000;
    else nv = nv_full[31:0];
    diff = 34'(signed'(old_rd)) - 34'(nv);
    mag  = diff[33] ? 34'(-diff) : 34'(diff);
    d31  = (mag > 34'h07FFFFFFF) ? 31'h7FFFFFFF : mag[30:0];
    peak_new = peak_r;
    if (interior && resid_en_r && d31 > peak_r) peak_new = d31;
  end

  logic [31:0] wb_val;
  assign wb_val = method_r ? nv : old_rd;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pss_pkg::ST_IDLE:   if (accept) state_nxt = pss_pkg::ST_READ;
      pss_pkg::ST_READ:   state_nxt = (op_r == pss_pkg::OP_LOAD) ? pss_pkg::ST_IDLE
                                                                 : pss_pkg::ST_FORCE1;
      pss_pkg::ST_FORCE1: state_nxt = pss_pkg::ST_FORCE2;
      pss_pkg::ST_FORCE2: state_nxt = pss_pkg::ST_CALC;
      pss_pkg::ST_CALC:   state_nxt = pss_pkg::ST_EMIT1;
      pss_pkg::ST_EMIT1: begin
        if (!has1_r || !out_v_r || !out_stall)
          state_nxt = pss_pkg::ST_EMIT2;
      end
      pss_pkg::ST_EMIT2: begin
        if (!has2_r || !out_v_r || !out_stall)
          state_nxt = pss_pkg::ST_IDLE;
      end
      default: state_nxt = pss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pss_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // capture of input beat
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      x_r    <= in_grid_value;
      tidx_r <= in_table_index;
      tval_r <= in_table_value;
      r_r    <= r_use;
      c_r    <= c_use;
    end
  end

  // forcing products
  always_ff @(posedge clk) begin
    if (state_r == pss_pkg::ST_FORCE1) t_r <= prod1[54:23];
    if (state_r == pss_pkg::ST_FORCE2) f_r <= prod2[55:23];
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (state_r == pss_pkg::ST_READ && op_r == pss_pkg::OP_LOAD
        && 32'(tidx_r) < 32'(pss_pkg::MAX_GRID))
      sine_mem[tidx_r[AW-1:0]] <= tval_r;
    if (state_r == pss_pkg::ST_CALC) begin
      centre_mem[c_r[AW-1:0]] <= x_r;
      if (r_r != 10'd0) upper_mem[c_r[AW-1:0]] <= wb_val;
    end
  end

  // counters, left neighbour, peak
  logic [9:0] col_inc;
  assign col_inc = c_r + 10'd1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      left_r <= '0;
      peak_r <= '0;
    end else begin
      if (accept && in_opcode == pss_pkg::OP_GRID) begin
        row_r <= r_use;
        col_r <= c_use;
        if (r_use == '0 && c_use == '0) begin
          left_r <= '0;
          peak_r <= '0;
        end
      end
      if (state_r == pss_pkg::ST_CALC) begin
        if (r_r != 10'd0) begin
          left_r <= wb_val;
          peak_r <= peak_new;
        end
        if ({1'b0, col_inc} > n_eff) begin
          col_r <= '0;
          row_r <= ({1'b0, r_r} + 11'd1 > n_eff) ? 10'd0 : r_r + 10'd1;
        end else begin
          col_r <= col_inc;
          row_r <= r_r;
        end
      end
    end
  end

  // results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has1_r <= 1'b0;
      has2_r <= 1'b0;
    end else if (state_r == pss_pkg::ST_CALC) begin
      has1_r <= (r_r != 10'd0);
      has2_r <= ({1'b0, r_r} == n_eff);
    end else if (state_r == pss_pkg::ST_EMIT1 && state_nxt == pss_pkg::ST_EMIT2) begin
      has1_r <= 1'b0;
    end else if (state_r == pss_pkg::ST_EMIT2 && state_nxt == pss_pkg::ST_IDLE) begin
      has2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pss_pkg::ST_CALC) begin
      res1_r.value <= nv;
      res1_r.row   <= r_r - 10'd1;
      res1_r.col   <= c_r;
      res1_r.last  <= 1'b0;
      res1_r.peak  <= (r_r != 10'd0) ? peak_new : peak_r;
      res1_r.conv  <= 1'b0;
      res2_r.value <= x_r;
      res2_r.row   <= r_r;
      res2_r.col   <= c_r;
      res2_r.last  <= ({1'b0, c_r} == n_eff);
      res2_r.peak  <= (r_r != 10'd0) ? peak_new : peak_r;
      res2_r.conv  <= ({1'b0, c_r} == n_eff)
                      && (((r_r != 10'd0) ? peak_new : peak_r) < prec_r);
    end
  end

  // output register
  logic load1, load2;
  assign load1 = state_r == pss_pkg::ST_EMIT1 && has1_r && (!out_v_r || !out_stall);
  assign load2 = state_r == pss_pkg::ST_EMIT2 && has2_r && (!out_v_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load1 || load2) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) out_r <= res1_r;
    else if (load2) out_r <= res2_r;
  end

  assign out_valid        = out_v_r;
  assign out_point_value  = out_r.value;
  assign out_point_row    = out_r.row;
  assign out_point_col    = out_r.col;
  assign out_sweep_last   = out_r.last;
  assign out_max_residual = out_r.peak;
  assign out_converged    = out_r.conv;

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != pss_pkg::ST_IDLE |-> in_stall)
    else $error("beat accepted while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_value))
    else $error("stalled result changed");

  a_conv_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_converged |-> out_sweep_last)
    else $error("converged off the last point");

endmodule

// File: bench/poisson_stencil_sweep_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poisson_stencil_sweep_core_tb
// Self-checking bench for the stencil sweep core. A directed table covers
// reset defaults, value extremes, sine loads and boundary pass-through; a
// random part then runs whole sweeps under changing grid sizes, methods and
// forcing settings. Every result beat is checked against a local predictor.
// ----------------------------------------------------------------------------
module poisson_stencil_sweep_core_tb;

  localparam int unsigned GRID_MAX = 1024;
  localparam int unsigned SWEEP_PAUSE = 16;  // drain cycles before a cfg write

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [30:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic signed [31:0] in_grid_value;
  logic [9:0]  in_table_index;
  logic [23:0] in_table_value;
  logic        out_valid;
  logic        out_stall;
  logic signed [31:0] out_point_value;
  logic [9:0]  out_point_row;
  logic [9:0]  out_point_col;
  logic        out_sweep_last;
  logic [30:0] out_max_residual;
  logic        out_converged;

  poisson_stencil_sweep_core DUT (.*);

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state, own copy of registers and line buffers
  logic [9:0]  grid_n;
  logic        gauss_seidel;
  logic        force_on;
  logic [30:0] force_amp;
  logic        resid_on;
  logic [30:0] prec_lim;
  logic [31:0] centre_line [GRID_MAX];
  logic [31:0] upper_line  [GRID_MAX];
  logic [23:0] sine_tab    [GRID_MAX];
  logic [9:0]  row_pos, col_pos;
  logic [31:0] left_val;
  logic [30:0] peak_resid;

  pss_pkg::result_t expected_points[$];
  int      err_count;
  bit      stim_done;

  // one grid beat through the predictor; pushes zero to two result beats
  task automatic stencil_predict(input logic [31:0] gv);
    int unsigned n, r, c, pr;
    longint old_v, new_v, sum, q, d, x;
    longint unsigned t, f;
    pss_pkg::result_t res;
    n = grid_n;
    if (n < 2) n = 2;
    if (n > GRID_MAX - 1) n = GRID_MAX - 1;
    if (row_pos > n || col_pos > n) begin
      row_pos = 0;
      col_pos = 0;
    end
    if (row_pos == 0 && col_pos == 0) begin
      peak_resid = '0;
      left_val = '0;
    end
    r = row_pos;
    c = col_pos;
    x = longint'($signed(gv));
    if (r >= 1) begin
      pr = r - 1;
      old_v = longint'($signed(centre_line[c]));
      new_v = old_v;
      if (pr >= 1 && pr <= n - 1 && c >= 1 && c <= n - 1) begin
        sum = longint'($signed(upper_line[c])) + longint'($signed(left_val))
            + longint'($signed(centre_line[c+1])) + x;
        q = sum >>> 2;  // floor division by four
        if (force_on) begin
          t = (longint'(force_amp) * sine_tab[pr] + (64'd1 << 22)) >> 23;
          f = (t * sine_tab[c] + (64'd1 << 22)) >> 23;
          q = q + longint'(f);
        end
        if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
        if (q < -64'sh80000000) q = -64'sh80000000;
        new_v = q;
        if (resid_on) begin
          d = old_v - new_v;
          if (d < 0) d = -d;
          if (d > 64'sh7FFFFFFF) d = 64'sh7FFFFFFF;
          if (d > longint'(peak_resid)) peak_resid = d[30:0];
        end
      end
      upper_line[c] = gauss_seidel ? new_v[31:0] : old_v[31:0];
      left_val      = gauss_seidel ? new_v[31:0] : old_v[31:0];
      res = '{value: new_v[31:0], row: pr[9:0], col: c[9:0], last: 1'b0,
              peak: peak_resid, conv: 1'b0};
      expected_points.push_back(res);
    end
    centre_line[c] = gv;
    if (r == n) begin
      res = '{value: gv, row: r[9:0], col: c[9:0], last: (c == n),
              peak: peak_resid, conv: (c == n) && (peak_resid < prec_lim)};
      expected_points.push_back(res);
    end
    if (c + 1 > n) begin
      col_pos = '0;
      row_pos = (r + 1 > n) ? 10'd0 : 10'(r + 1);
    end else begin
      col_pos = 10'(c + 1);
    end
  endtask

  // ---- stimulus driving ----
  // valid stays high after a beat; it drops when a gap is drawn or on drain
  task automatic send_beat(input pss_pkg::opcode_t op, input logic [31:0] gv,
                           input logic [9:0] idx, input logic [23:0] tv);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_grid_value  <= gv;
    in_table_index <= idx;
    in_table_value <= tv;
    // accept edge: valid high and stall low
    do @(posedge clk); while (in_stall);
    if (op == pss_pkg::OP_LOAD) sine_tab[idx] = tv;
    else stencil_predict(gv);
  endtask

  // wait for drain, then hold off for in-flight work that makes no result
  task automatic drain_wait();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SWEEP_PAUSE) @(posedge clk);
  endtask

  task automatic cfg_write(input pss_pkg::cfg_idx_t idx, input logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      pss_pkg::CFG_GRID:      grid_n       = val[9:0];
      pss_pkg::CFG_METHOD:    gauss_seidel = val[0];
      pss_pkg::CFG_FORCE_EN:  force_on     = val[0];
      pss_pkg::CFG_SCALE:     force_amp    = val;
      pss_pkg::CFG_RESID_EN:  resid_on     = val[0];
      pss_pkg::CFG_PRECISION: prec_lim     = val;
      default: ;
    endcase
  endtask

  // sines for every index a sweep of size n can read
  task automatic load_sines(input int unsigned n);
    for (int unsigned k = 0; k <= n; k++)
      send_beat(pss_pkg::OP_LOAD, $urandom, k[9:0],
                ($urandom_range(0, 7) == 0) ? 24'h800000 : 24'($urandom_range(0, 8388608)));
  endtask

  function automatic logic [31:0] rand_grid();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2 ** 26)) - 2 ** 25);
      default: return $urandom;
    endcase
  endfunction

  // one whole sweep of the current size
  task automatic run_sweep();
    int unsigned n;
    n = (grid_n < 2) ? 2 : grid_n;
    for (int unsigned p = 0; p < (n + 1) * (n + 1); p++)
      send_beat(pss_pkg::OP_GRID, rand_grid(), 10'($urandom), 24'($urandom));
  endtask

  // directed table: after reset N = 8, Jacobi, no forcing
  typedef struct {
    pss_pkg::opcode_t op;
    logic [31:0] gv;
    logic [9:0]  idx;
    logic [23:0] tv;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    int unsigned sweeps;
    dir_row_t dr;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pss_pkg::CFG_GRID;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_opcode = pss_pkg::OP_GRID;
    in_grid_value = '0;
    in_table_index = '0;
    in_table_value = '0;
    err_count = 0;
    stim_done = 0;
    grid_n = 10'd8;
    gauss_seidel = 1'b0;
    force_on = 1'b0;
    force_amp = '0;
    resid_on = 1'b1;
    prec_lim = '0;
    row_pos = '0;
    col_pos = '0;
    left_val = '0;
    peak_resid = '0;
    for (int i = 0; i < GRID_MAX; i++) begin
      centre_line[i] = '0;
      upper_line[i]  = '0;
      sine_tab[i]    = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: loads at extremes (including the top index),
    // then row zero of extremes, which emits nothing
    dir_rows.push_back('{pss_pkg::OP_LOAD, 32'h0, 10'd0,    24'h800000});
    dir_rows.push_back('{pss_pkg::OP_LOAD, 32'h0, 10'd1023, 24'h000000});
    dir_rows.push_back('{pss_pkg::OP_LOAD, 32'hFFFFFFFF, 10'h3FF, 24'hFFFFFF});
    for (int i = 0; i < 9; i++)
      dir_rows.push_back('{pss_pkg::OP_GRID, (i % 2) ? 32'h80000000 : 32'h7FFFFFFF,
                           10'd0, 24'd0});
    for (int i = 0; i < 9; i++)
      dir_rows.push_back('{pss_pkg::OP_GRID, 32'hFFFFFFFF, 10'h3FF, 24'hFFFFFF});
    foreach (dir_rows[i]) begin
      dr = dir_rows[i];
      send_beat(dr.op, dr.gv, dr.idx, dr.tv);
    end
    in_valid <= 1'b0;
    // row one: first emitted beat is boundary (0,0) passing through max positive
    while (expected_points.size() != 0) @(posedge clk);
    // finish the reset-size sweep
    for (int p = 18; p < 81; p++)
      send_beat(pss_pkg::OP_GRID, rand_grid(), 10'd0, 24'd0);
    drain_wait();

    // every register written, extremes first: smallest grid, all features on
    cfg_write(pss_pkg::CFG_GRID, 31'd2);
    cfg_write(pss_pkg::CFG_METHOD, 31'd1);
    cfg_write(pss_pkg::CFG_FORCE_EN, 31'd1);
    cfg_write(pss_pkg::CFG_SCALE, 31'h7FFFFFFF);
    cfg_write(pss_pkg::CFG_RESID_EN, 31'd1);
    cfg_write(pss_pkg::CFG_PRECISION, 31'h7FFFFFFF);
    load_sines(2);
    run_sweep();
    drain_wait();
    // below-range grid acts as two; residual off
    cfg_write(pss_pkg::CFG_GRID, 31'd0);
    cfg_write(pss_pkg::CFG_RESID_EN, 31'd0);
    cfg_write(pss_pkg::CFG_PRECISION, 31'd0);
    run_sweep();
    drain_wait();

    // random sweeps with random settings; sizes from two to six
    sweeps = 0;
    while (sweeps < 20) begin
      cfg_write(pss_pkg::CFG_GRID, 31'($urandom_range(2, 6)));
      cfg_write(pss_pkg::CFG_METHOD, 31'($urandom_range(0, 1)));
      cfg_write(pss_pkg::CFG_FORCE_EN, 31'($urandom_range(0, 1)));
      cfg_write(pss_pkg::CFG_SCALE, ($urandom_range(0, 1)) ? 31'h7FFFFFFF : 31'($urandom));
      cfg_write(pss_pkg::CFG_RESID_EN, 31'($urandom_range(0, 3) != 0));
      cfg_write(pss_pkg::CFG_PRECISION,
                ($urandom_range(0, 1)) ? 31'h7FFFFFFF : 31'($urandom));
      if (force_on) load_sines(grid_n);
      run_sweep();
      drain_wait();
      sweeps++;
    end
    // one larger sweep
    cfg_write(pss_pkg::CFG_GRID, 31'd12);
    cfg_write(pss_pkg::CFG_FORCE_EN, 31'd1);
    load_sines(12);
    run_sweep();
    drain_wait();
    stim_done = 1;
  end

  // ---- result side: random stall, compare against oldest expectation ----
  int stall_left;
  initial begin
    out_stall = 1'b1;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected beat row %0d col %0d value %h", $time,
                   out_point_row, out_point_col, out_point_value);
          err_count++;
        end else begin
          pss_pkg::result_t e;
          e = expected_points.pop_front();
          if (out_point_value !== e.value) begin
            $display("%0t: value exp %h got %h", $time, e.value, out_point_value);
            err_count++;
          end
          if (out_point_row !== e.row) begin
            $display("%0t: row exp %0d got %0d", $time, e.row, out_point_row);
            err_count++;
          end
          if (out_point_col !== e.col) begin
            $display("%0t: col exp %0d got %0d", $time, e.col, out_point_col);
            err_count++;
          end
          if (out_sweep_last !== e.last) begin
            $display("%0t: last exp %b got %b", $time, e.last, out_sweep_last);
            err_count++;
          end
          if (out_max_residual !== e.peak) begin
            $display("%0t: peak exp %h got %h", $time, e.peak, out_max_residual);
            err_count++;
          end
          if (out_converged !== e.conv) begin
            $display("%0t: conv exp %b got %b", $time, e.conv, out_converged);
            err_count++;
          end
        end
        stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---- end of run ----
  initial begin
    wait (stim_done);
    repeat (40) @(posedge clk);
    if (err_count == 0 && expected_points.size() == 0)
      $display("poisson_stencil_sweep_core test passed");
    else
      $display("poisson_stencil_sweep_core test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("poisson_stencil_sweep_core test failed");
    $finish;
  end

endmodule
